>>> rtl/bezier_surface_evaluator_assert.svh
// Assertion macros shared by the bezier surface evaluator RTL.
// Each macro expects the signals aclk and aresetn in the using scope.
`ifndef BEZIER_SURFACE_EVALUATOR_ASSERT_SVH
`define BEZIER_SURFACE_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define BSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier surface evaluator package
// Shared constants, state types and the binomial coefficient table.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int CW = 24;
    localparam int PW = 18;
    localparam int TW = 31;
    localparam int BW = 32;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_EVAL  = 1'b1;
    localparam logic [2:0] PPS_RESET = 3'd7;
    localparam logic [TW-1:0] ONE_Q30 = TW'(1) << 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASIS,
        ST_ACC,
        ST_DRAIN,
        ST_DONE
    } bse_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_POW,
        BS_TERM,
        BS_SCALE
    } bse_bstate_t;

    typedef struct packed {
        logic       start;
        logic [2:0] nm1;
    } bse_basis_cmd_t;

    localparam logic [4:0] BINOM_TAB [7][7] = '{
        '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
        '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
        '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
    };

    function automatic logic [4:0] binom(input logic [2:0] nm1, input logic [2:0] i);
        logic [4:0] r;
        r = 5'd0;
        if (nm1 != 3'd7 && i != 3'd7) begin
            r = BINOM_TAB[nm1][i];
        end
        return r;
    endfunction

endpackage

>>> rtl/bse_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control point memory
// Single write port and single registered read port; read data appears in the cycle after the read.
// ----------------------------------------------------------------------------
module bse_grid_mem #(
    parameter int DEPTH = 49,
    parameter int AW    = 6,
    parameter int DW    = 72
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bse_basis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bernstein basis unit
// Builds one degree n-1 basis; powers and terms share one Q1.30 multiplier.
// ----------------------------------------------------------------------------
module bse_basis #(
    parameter int MAX_POINTS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bse_pkg::bse_basis_cmd_t           cmd,
    input  logic [bse_pkg::TW-1:0]            t_q30,
    input  logic [$clog2(MAX_POINTS)-1:0]     rd_idx,
    output logic [bse_pkg::BW-1:0]            rd_b,
    output logic                              done
);
    import bse_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    bse_bstate_t   state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic          sub_reg, sub_next;
    logic [IW-1:0] nm1_reg;
    logic [TW-1:0] t_reg, w_reg;
    logic [TW-1:0] tp [MAX_POINTS];
    logic [TW-1:0] wp [MAX_POINTS];
    logic [BW-1:0] b_arr [MAX_POINTS];
    logic [TW-1:0] prod_reg;
    logic [TW-1:0] op_a, op_b;
    logic [2*TW-1:0] mul_full;
    logic [TW-1:0] mul_rnd;
    logic [35:0]   scaled;

    always_comb begin
        op_a = tp[k_reg];
        op_b = wp[nm1_reg - k_reg];
        if (state_reg == BS_POW) begin
            op_a = sub_reg ? wp[k_reg - IW'(1)] : tp[k_reg - IW'(1)];
            op_b = sub_reg ? w_reg : t_reg;
        end
    end

    assign mul_full = op_a * op_b + (2*TW)'(1 << 29);
    assign mul_rnd  = mul_full[60:30];
    assign scaled   = binom(3'(nm1_reg), 3'(k_reg)) * prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            k_reg     <= '0;
            sub_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            sub_reg   <= sub_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        sub_next   = sub_reg;
        done       = 1'b0;
        case (state_reg)
            BS_IDLE: begin
                if (cmd.start) begin
                    state_next = BS_POW;
                    k_next     = IW'(1);
                    sub_next   = 1'b0;
                end
            end
            BS_POW: begin
                sub_next = ~sub_reg;
                if (sub_reg) begin
                    if (k_reg == nm1_reg) begin
                        k_next     = '0;
                        state_next = BS_TERM;
                    end else begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end
            BS_TERM: begin
                state_next = BS_SCALE;
            end
            BS_SCALE: begin
                if (k_reg == nm1_reg) begin
                    done       = 1'b1;
                    state_next = BS_IDLE;
                end else begin
                    k_next     = k_reg + IW'(1);
                    state_next = BS_TERM;
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BS_IDLE && cmd.start) begin
            t_reg   <= t_q30;
            w_reg   <= ONE_Q30 - t_q30;
            nm1_reg <= cmd.nm1[IW-1:0];
            tp[0]   <= ONE_Q30;
            wp[0]   <= ONE_Q30;
        end
        if (state_reg == BS_POW) begin
            if (sub_reg) begin
                wp[k_reg] <= mul_rnd;
            end else begin
                tp[k_reg] <= mul_rnd;
            end
        end
        if (state_reg == BS_TERM) begin
            prod_reg <= mul_rnd;
        end
        if (state_reg == BS_SCALE) begin
            b_arr[k_reg] <= scaled[BW-1:0];
        end
    end

    assign rd_b = b_arr[rd_idx];

endmodule

>>> rtl/bezier_surface_evaluator.sv
`timescale 1ns / 1ps
// An evaluation runs both basis units, reads its n*n grid points one per cycle,
// drains the product pipeline, then loads the result and raises m_tvalid, n being
// the points per side in use. No transfer, write or evaluation, is taken until the
// result of the last evaluation has been loaded into the output register.
// Reset: synchronous active-low; clears the control logic and sets the size to 7.
// ----------------------------------------------------------------------------
// Bezier surface evaluator
// Tensor-product Bezier surface over a stored grid of fixed-point points.
// ----------------------------------------------------------------------------
`include "bezier_surface_evaluator_assert.svh"
module bezier_surface_evaluator #(
    parameter int MAX_POINTS = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // grid_row, grid_col, point_x, point_y, point_z, param_u, param_v, zero pad
    input  logic [119:0]  s_tdata,
    // op
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // surf_x, surf_y, surf_z, clipped, zero pad
    output logic [79:0]   m_tdata
);
    import bse_pkg::*;

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int AccW  = 62;

    bse_state_t state_reg, state_next;
    logic [2:0]    pps_reg;
    logic [2:0]    n_eff;
    logic [IW-1:0] nm1_reg, nm1_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;

    logic          accept;
    logic [2:0]    row, col;
    logic signed [CW-1:0] px, py, pz;
    logic signed [PW-1:0] pu, pv;
    logic [TW-1:0] u_q30, v_q30;

    logic          mem_we, mem_re;
    logic [AW-1:0] waddr, raddr;
    logic [3*CW-1:0] rdata;

    bse_basis_cmd_t cmd;
    logic [BW-1:0]  bu, bv;
    logic           bu_done, bv_done;

    logic [2*BW-1:0] w_full;
    logic [BW-1:0]   w_reg;
    logic            v1_reg, v2_reg;
    logic signed [BW+CW:0] prx_reg, pry_reg, prz_reg;
    logic signed [AccW-1:0] accx_reg, accy_reg, accz_reg;
    logic            m_tvalid_reg;
    logic [79:0]     m_tdata_reg;
    logic            load_out;
    logic [CW-1:0]   rx, ry, rz;
    logic            cx, cy, cz;

    function automatic logic [TW-1:0] clamp_q30(input logic signed [PW-1:0] p);
        logic [16:0] c;
        c = p[16:0];
        if (p[PW-1]) begin
            c = '0;
        end else if (p > PW'(65536)) begin
            c = 17'd65536;
        end
        return {c, 14'd0};
    endfunction

    function automatic logic [CW:0] finish(input logic signed [AccW-1:0] acc);
        logic signed [AccW:0] s;
        logic signed [AccW-30:0] r;
        logic [CW-1:0] o;
        logic clip;
        s = {acc[AccW-1], acc} + (AccW+1)'(1 << 29);
        r = s[AccW:30];
        o = r[CW-1:0];
        clip = 1'b0;
        if (r > (AccW-29)'(8388607)) begin
            o = 24'h7FFFFF;
            clip = 1'b1;
        end else if (r < -(AccW-29)'(8388608)) begin
            o = 24'h800000;
            clip = 1'b1;
        end
        return {clip, o};
    endfunction

    assign row = s_tdata[2:0];
    assign col = s_tdata[5:3];
    assign px  = s_tdata[29:6];
    assign py  = s_tdata[53:30];
    assign pz  = s_tdata[77:54];
    assign pu  = s_tdata[95:78];
    assign pv  = s_tdata[113:96];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pps_reg <= PPS_RESET;
        end else if (cfg_wr_en) begin
            pps_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        n_eff = pps_reg;
        if (pps_reg < 3'd2) begin
            n_eff = 3'd2;
        end else if (pps_reg > 3'(MAX_POINTS)) begin
            n_eff = 3'(MAX_POINTS);
        end
    end

    assign u_q30 = clamp_q30(pu);
    assign v_q30 = clamp_q30(pv);

    assign mem_we = accept && (s_tuser == OP_WRITE) &&
                    (row < 3'(MAX_POINTS)) && (col < 3'(MAX_POINTS));
    assign waddr  = AW'(row * MAX_POINTS + col);
    assign mem_re = (state_reg == ST_ACC);
    assign raddr  = AW'(i_reg * MAX_POINTS + j_reg);

    bse_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (3 * CW)
    ) u_grid (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata ({pz, py, px}),
        .re    (mem_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cmd.start = accept && (s_tuser == OP_EVAL);
    assign cmd.nm1   = n_eff - 3'd1;

    bse_basis #(.MAX_POINTS(MAX_POINTS)) u_basis_u (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .t_q30   (u_q30),
        .rd_idx  (j_reg),
        .rd_b    (bu),
        .done    (bu_done)
    );

    bse_basis #(.MAX_POINTS(MAX_POINTS)) u_basis_v (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .t_q30   (v_q30),
        .rd_idx  (i_reg),
        .rd_b    (bv),
        .done    (bv_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nm1_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nm1_reg   <= nm1_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            v1_reg    <= mem_re;
            v2_reg    <= v1_reg;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        nm1_next   = nm1_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    nm1_next   = cmd.nm1[IW-1:0];
                    state_next = ST_BASIS;
                end
            end
            ST_BASIS: begin
                if (bu_done) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (j_reg == nm1_reg) begin
                    j_next = '0;
                    if (i_reg == nm1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign w_full = bv * bu + (2*BW)'(1 << 29);

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            w_reg <= w_full[61:30];
        end
        if (v1_reg) begin
            prx_reg <= $signed({1'b0, w_reg}) * $signed(rdata[CW-1:0]);
            pry_reg <= $signed({1'b0, w_reg}) * $signed(rdata[2*CW-1:CW]);
            prz_reg <= $signed({1'b0, w_reg}) * $signed(rdata[3*CW-1:2*CW]);
        end
        if (state_reg == ST_BASIS) begin
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
        end else if (v2_reg) begin
            accx_reg <= accx_reg + AccW'(prx_reg);
            accy_reg <= accy_reg + AccW'(pry_reg);
            accz_reg <= accz_reg + AccW'(prz_reg);
        end
        if (load_out) begin
            m_tdata_reg <= {7'd0, cx | cy | cz, rz, ry, rx};
        end
    end

    assign {cx, rx} = finish(accx_reg);
    assign {cy, ry} = finish(accy_reg);
    assign {cz, rz} = finish(accz_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BSE_ASSERT_IMP(a_lanes_agree, 1'b1, bu_done == bv_done, "basis lanes out of step")
    `BSE_ASSERT_IMP(a_no_write_busy, mem_we, state_reg == ST_IDLE, "grid write while busy")
    `BSE_ASSERT_IMP(a_acc_bounds, state_reg == ST_ACC, i_reg <= nm1_reg && j_reg <= nm1_reg,
                    "grid index beyond size")
    `BSE_ASSERT_NXT(a_load_valid, load_out, m_tvalid, "result not presented after load")

endmodule

>>> tb/bezier_surface_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier surface evaluator testbench
// Loads a control grid, sweeps the points-per-side register through several
// settings, including the out-of-range values, and sends point writes and
// surface evaluations under random stalls on both streams. Every result is
// checked field by field against a fixed-point surface predictor.
// ----------------------------------------------------------------------------
module bezier_surface_evaluator_tb;
    import bse_pkg::*;

    typedef struct {
        logic        op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] pz;
        logic [17:0] pu;
        logic [17:0] pv;
    } grid_item_t;

    typedef struct {
        logic [23:0] sx;
        logic [23:0] sy;
        logic [23:0] sz;
        logic        clip;
    } surf_point_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;

    grid_item_t   pending_items[$];
    surf_point_t  expected_points[$];
    logic signed [23:0] grid_pts[49][3];
    logic [2:0]   side_setting;
    logic         took;
    logic         quiet;
    int           send_gap;
    int           recv_gap;
    int           mismatches;

    bezier_surface_evaluator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b + (64'd1 << 29);
        return p >> 30;
    endfunction

    function automatic int choose(input int n, input int k);
        int c;
        c = 1;
        for (int i = 1; i <= k; i++) begin
            c = c * (n - i + 1) / i;
        end
        return c;
    endfunction

    function automatic logic [63:0] clamp_param(input logic [17:0] raw);
        logic signed [17:0] p;
        logic [63:0] t;
        p = raw;
        if (p < 0) begin
            t = 0;
        end else if (p > 18'sd65536) begin
            t = 64'd65536;
        end else begin
            t = 64'(p);
        end
        return t << 14;
    endfunction

    function automatic void bernstein(input logic [63:0] t, input int n,
                                      output logic [63:0] b[7]);
        logic [63:0] tp[7];
        logic [63:0] wp[7];
        logic [63:0] w;
        w = (64'd1 << 30) - t;
        tp[0] = 64'd1 << 30;
        wp[0] = 64'd1 << 30;
        for (int i = 1; i < n; i++) begin
            tp[i] = qmul(tp[i-1], t);
            wp[i] = qmul(wp[i-1], w);
        end
        for (int i = 0; i < 7; i++) begin
            b[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            b[i] = 64'(choose(n - 1, i)) * qmul(tp[i], wp[n-1-i]);
        end
    endfunction

    function automatic logic [23:0] round_coord(input logic signed [63:0] acc,
                                               inout logic clip);
        logic signed [63:0] r;
        r = (acc + 64'sd536870912) >>> 30;
        if (r > 64'sd8388607) begin
            r = 64'sd8388607;
            clip = 1'b1;
        end
        if (r < -64'sd8388608) begin
            r = -64'sd8388608;
            clip = 1'b1;
        end
        return r[23:0];
    endfunction

    task automatic predict_surface(input grid_item_t it);
        logic [63:0] bu[7];
        logic [63:0] bv[7];
        logic signed [63:0] acc[3];
        logic signed [63:0] w;
        surf_point_t sp;
        int n;
        if (it.op == OP_WRITE) begin
            if (it.row < 7 && it.col < 7) begin
                grid_pts[it.row*7+it.col][0] = it.px;
                grid_pts[it.row*7+it.col][1] = it.py;
                grid_pts[it.row*7+it.col][2] = it.pz;
            end
        end else begin
            n = side_setting;
            if (n < 2) n = 2;
            if (n > 7) n = 7;
            bernstein(clamp_param(it.pu), n, bu);
            bernstein(clamp_param(it.pv), n, bv);
            for (int c = 0; c < 3; c++) acc[c] = 0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    w = qmul(bv[i], bu[j]);
                    for (int c = 0; c < 3; c++) begin
                        acc[c] += w * 64'(grid_pts[i*7+j][c]);
                    end
                end
            end
            sp.clip = 1'b0;
            sp.sx = round_coord(acc[0], sp.clip);
            sp.sy = round_coord(acc[1], sp.clip);
            sp.sz = round_coord(acc[2], sp.clip);
            expected_points.push_back(sp);
        end
    endtask

    function automatic grid_item_t make_item(input logic op, input int row, input int col,
                                             input int x, input int y, input int z,
                                             input int u, input int v);
        grid_item_t it;
        it.op = op;
        it.row = 3'(row);
        it.col = 3'(col);
        it.px = 24'(x);
        it.py = 24'(y);
        it.pz = 24'(z);
        it.pu = 18'(u);
        it.pv = 18'(v);
        return it;
    endfunction

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8388607;
        if (r == 1) return -8388608;
        return int'($urandom);
    endfunction

    function automatic int rand_param();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 65536);
        return int'($urandom);
    endfunction

    function automatic grid_item_t rand_item();
        int r;
        int row;
        int col;
        r = $urandom_range(0, 99);
        row = $urandom_range(0, 6);
        col = $urandom_range(0, 6);
        if (r >= 95) begin
            if ($urandom_range(0, 1)) row = 7; else col = 7;
            row = $urandom_range(0, 1) ? 7 : row;
        end
        return make_item(r < 55 ? OP_EVAL : OP_WRITE, r < 55 ? $urandom_range(0, 7) : row,
                         r < 55 ? $urandom_range(0, 7) : col, rand_coord(), rand_coord(),
                         rand_coord(), rand_param(), rand_param());
    endfunction

    // Input side: accepted transfers are predicted at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_surface(pending_items[0]);
            void'(pending_items.pop_front());
            took = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !took)) begin
            took = 1'b0;
            if (send_gap == 0 && !quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 15);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].op;
                s_tdata  <= {6'd0, pending_items[0].pv, pending_items[0].pu,
                             pending_items[0].pz, pending_items[0].py,
                             pending_items[0].px, pending_items[0].col,
                             pending_items[0].row};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_gap == 0 && !quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 15);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result transfer: %h", m_tdata);
                end
            end else begin
                if (m_tdata[23:0] !== expected_points[0].sx ||
                    m_tdata[47:24] !== expected_points[0].sy ||
                    m_tdata[71:48] !== expected_points[0].sz ||
                    m_tdata[72] !== expected_points[0].clip) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected x=%h y=%h z=%h clip=%b, got x=%h y=%h z=%h clip=%b",
                                 expected_points[0].sx, expected_points[0].sy,
                                 expected_points[0].sz, expected_points[0].clip,
                                 m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tdata[72]);
                    end
                end
                void'(expected_points.pop_front());
            end
        end
    end

    task automatic drain_and_settle();
        wait (pending_items.size() == 0 && !s_tvalid && expected_points.size() == 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_side_setting(input logic [2:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        side_setting = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [2:0] settings[9];
        settings = '{3'd7, 3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd6, 3'd4, 3'd7};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 3'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        side_setting = PPS_RESET;
        took = 1'b0;
        quiet = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        mismatches = 0;
        for (int i = 0; i < 49; i++) begin
            for (int c = 0; c < 3; c++) grid_pts[i][c] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill the whole grid so no evaluation reads an unwritten point.
        for (int i = 0; i < 49; i++) begin
            pending_items.push_back(make_item(OP_WRITE, i / 7, i % 7,
                                    (i % 2) ? 8388607 : -8388608,
                                    (i % 3) ? -8388608 : 8388607,
                                    rand_coord(), 0, 0));
        end
        pending_items.push_back(make_item(OP_WRITE, 7, 3, 100, 100, 100, 0, 0));
        pending_items.push_back(make_item(OP_WRITE, 2, 7, 100, 100, 100, 0, 0));
        pending_items.push_back(make_item(OP_WRITE, 7, 7, 100, 100, 100, 0, 0));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0, 65536, 65536));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0, 32768, 32768));
        pending_items.push_back(make_item(OP_EVAL, 7, 7, -1, -1, -1, -131072, 131071));
        pending_items.push_back(make_item(OP_EVAL, 7, 7, -1, -1, -1, 131071, -1));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0, 65537, 65535));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0, 1, 65535));

        for (int p = 0; p < 9; p++) begin
            drain_and_settle();
            write_side_setting(settings[p]);
            if (p == 8) quiet = 1'b1;
            for (int k = 0; k < 200; k++) begin
                pending_items.push_back(rand_item());
            end
        end
        drain_and_settle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
